// ----- src/srsd_pkg.sv -----
// Shared types and constants of the sensor record stream deframer.
// Used by the parser front end, the entry queue and the result emitter.
// Depends on nothing.
`default_nettype none

package srsd_pkg;

   // Record type codes
   localparam logic [7:0] TYPE_IMAGE = 8'h00;
   localparam logic [7:0] TYPE_GYRO  = 8'h01;
   localparam logic [7:0] TYPE_ACCEL = 8'h02;
   localparam logic [7:0] TYPE_MAG   = 8'h03;
   localparam logic [7:0] TYPE_ALT   = 8'h04;
   localparam logic [7:0] TYPE_GPS   = 8'h05;
   localparam logic [7:0] TYPE_H264  = 8'h08;

   // Field index codes
   localparam logic [2:0] FIELD_TIMESTAMP = 3'd0;
   localparam logic [2:0] FIELD_FIRST     = 3'd1;
   localparam logic [2:0] FIELD_HEIGHT    = 3'd2;
   localparam logic [2:0] FIELD_LAST_UNIT = 3'd3;
   localparam logic [2:0] FIELD_END       = 3'd7;

   // Bit of the enable mask that gates unknown-type reports
   localparam int unsigned UNKNOWN_ENABLE_BIT = 6;
   localparam int unsigned ENABLE_W           = 7;

   // One result item
   typedef struct packed {
      logic [7:0]  record_type;
      logic [2:0]  field_index;
      logic [63:0] value;
      logic        is_payload_byte;
      logic        unit_end;
      logic        record_end;
      logic        unknown_type;
   } result_type;

   // One queue entry: a result, optionally led by the Annex B start code
   typedef struct packed {
      result_type res;
      logic       start_code;
   } entry_type;

endpackage

`default_nettype wire

// ----- src/srsd_front.sv -----
// Parser front end: accepts stream bytes, tracks the record position and
// pushes one classified entry per completed field or payload byte. Depends on srsd_pkg.
`default_nettype none

module srsd_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [srsd_pkg::ENABLE_W-1:0]     csr_type_enable,
   input  wire logic                              accept,
   input  wire logic [7:0]                        data_byte,
   output logic                                   ent_push,
   output srsd_pkg::entry_type                    ent
);

   typedef enum logic [7:0] {
      PH_TYPE   = 8'b0000_0001,
      PH_TS     = 8'b0000_0010,
      PH_WIDTH  = 8'b0000_0100,
      PH_HEIGHT = 8'b0000_1000,
      PH_PIXELS = 8'b0001_0000,
      PH_VALUES = 8'b0010_0000,
      PH_LEN    = 8'b0100_0000,
      PH_UNIT   = 8'b1000_0000
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [2:0]                      bc_ff, bc_in;
   logic [63:0]                     shift_ff, shift_in;
   logic [7:0]                      type_ff, type_in;
   logic [31:0]                     rem_ff, rem_in;
   logic [31:0]                     width_ff, width_in;
   logic [2:0]                      fnum_ff, fnum_in;
   logic                            pend_ff, pend_in;
   logic [srsd_pkg::ENABLE_W-1:0]   mask_ff;

   logic [63:0] shifted;
   logic [31:0] v32;
   logic [63:0] prod_full;
   logic [31:0] area;
   logic [3:0]  bc_next;
   logic        done8;
   logic        done4;
   logic [31:0] rem_dec;
   logic        emit;
   logic        enabled;

   assign shifted   = {data_byte, shift_ff[63:8]};
   assign v32       = shifted[63:32];
   assign prod_full = width_ff * v32;
   assign area      = prod_full[31:0];
   assign bc_next   = {1'b0, bc_ff} + 4'd1;
   assign done8     = (bc_ff == 3'd7);
   assign done4     = (bc_next >= 4'd4);
   assign rem_dec   = rem_ff - 32'd1;

   // Gate results by the per-type enable mask
   always_comb begin
      if (type_ff <= srsd_pkg::TYPE_GPS) begin
         enabled = mask_ff[type_ff[2:0]];
      end else if (type_ff == srsd_pkg::TYPE_H264) begin
         enabled = mask_ff[0];
      end else begin
         enabled = mask_ff[srsd_pkg::UNKNOWN_ENABLE_BIT];
      end
   end

   assign ent_push = accept && emit && enabled;

   // Advance the parse position and build the entry for this byte
   always_comb begin
      phase_in = phase_ff;
      bc_in    = bc_ff;
      shift_in = shift_ff;
      type_in  = type_ff;
      rem_in   = rem_ff;
      width_in = width_ff;
      fnum_in  = fnum_ff;
      pend_in  = pend_ff;
      emit     = 1'b0;
      ent      = '0;
      ent.res.record_type = type_ff;
      if (accept) begin
         case (phase_ff)
            PH_TYPE: begin
               type_in  = data_byte;
               bc_in    = 3'd0;
               phase_in = PH_TS;
            end
            PH_TS: begin
               shift_in = shifted;
               bc_in    = done8 ? 3'd0 : bc_next[2:0];
               if (done8) begin
                  emit = 1'b1;
                  ent.res.field_index = srsd_pkg::FIELD_TIMESTAMP;
                  ent.res.value       = shifted;
                  if (type_ff == srsd_pkg::TYPE_IMAGE) begin
                     phase_in = PH_WIDTH;
                  end else if (type_ff <= srsd_pkg::TYPE_GPS) begin
                     if (type_ff <= srsd_pkg::TYPE_MAG) begin
                        rem_in = 32'd3;
                     end else if (type_ff == srsd_pkg::TYPE_ALT) begin
                        rem_in = 32'd2;
                     end else begin
                        rem_in = 32'd5;
                     end
                     fnum_in  = srsd_pkg::FIELD_FIRST;
                     phase_in = PH_VALUES;
                  end else if (type_ff == srsd_pkg::TYPE_H264) begin
                     fnum_in  = srsd_pkg::FIELD_FIRST;
                     phase_in = PH_LEN;
                  end else begin
                     ent.res.field_index  = srsd_pkg::FIELD_END;
                     ent.res.value        = '0;
                     ent.res.record_end   = 1'b1;
                     ent.res.unknown_type = 1'b1;
                     phase_in             = PH_TYPE;
                  end
               end
            end
            PH_WIDTH: begin
               shift_in = shifted;
               bc_in    = done4 ? 3'd0 : bc_next[2:0];
               if (done4) begin
                  emit                = 1'b1;
                  width_in            = v32;
                  ent.res.field_index = srsd_pkg::FIELD_FIRST;
                  ent.res.value       = {32'd0, v32};
                  phase_in            = PH_HEIGHT;
               end
            end
            PH_HEIGHT: begin
               shift_in = shifted;
               bc_in    = done4 ? 3'd0 : bc_next[2:0];
               if (done4) begin
                  emit                = 1'b1;
                  rem_in              = area;
                  ent.res.field_index = srsd_pkg::FIELD_HEIGHT;
                  ent.res.value       = {32'd0, v32};
                  ent.res.record_end  = (area == 32'd0);
                  phase_in            = (area == 32'd0) ? PH_TYPE : PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               emit                    = 1'b1;
               rem_in                  = rem_dec;
               ent.res.field_index     = srsd_pkg::FIELD_LAST_UNIT;
               ent.res.value           = {56'd0, data_byte};
               ent.res.is_payload_byte = 1'b1;
               ent.res.unit_end        = (rem_dec == 32'd0);
               ent.res.record_end      = (rem_dec == 32'd0);
               if (rem_dec == 32'd0) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_VALUES: begin
               shift_in = shifted;
               bc_in    = done8 ? 3'd0 : bc_next[2:0];
               if (done8) begin
                  emit                = 1'b1;
                  rem_in              = rem_dec;
                  ent.res.field_index = fnum_ff;
                  ent.res.value       = shifted;
                  ent.res.record_end  = (rem_dec == 32'd0);
                  fnum_in             = fnum_ff + 3'd1;
                  if (rem_dec == 32'd0) begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            PH_LEN: begin
               shift_in = shifted;
               bc_in    = done4 ? 3'd0 : bc_next[2:0];
               if (done4) begin
                  if (v32 != 32'd0) begin
                     rem_in   = v32;
                     pend_in  = 1'b1;
                     phase_in = PH_UNIT;
                  end else if (fnum_ff >= srsd_pkg::FIELD_LAST_UNIT) begin
                     // Zero NAL length closes the record
                     emit                = 1'b1;
                     ent.res.field_index = srsd_pkg::FIELD_END;
                     ent.res.value       = '0;
                     ent.res.record_end  = 1'b1;
                     phase_in            = PH_TYPE;
                  end else begin
                     // Empty SPS or PPS: skip to the next length
                     fnum_in = fnum_ff + 3'd1;
                  end
               end
            end
            PH_UNIT: begin
               emit                    = 1'b1;
               pend_in                 = 1'b0;
               rem_in                  = rem_dec;
               ent.start_code          = pend_ff;
               ent.res.field_index     = fnum_ff;
               ent.res.value           = {56'd0, data_byte};
               ent.res.is_payload_byte = 1'b1;
               ent.res.unit_end        = (rem_dec == 32'd0);
               if (rem_dec == 32'd0) begin
                  phase_in = PH_LEN;
                  if (fnum_ff < srsd_pkg::FIELD_LAST_UNIT) begin
                     fnum_in = fnum_ff + 3'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         bc_ff    <= 3'd0;
         type_ff  <= 8'd0;
         rem_ff   <= 32'd0;
         fnum_ff  <= 3'd0;
         pend_ff  <= 1'b0;
         mask_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         type_ff  <= type_in;
         rem_ff   <= rem_in;
         fnum_ff  <= fnum_in;
         pend_ff  <= pend_in;
         if (csr_write_enable) begin
            mask_ff <= csr_type_enable;
         end
      end
   end

   // Field assembly registers carry no reset
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      width_ff <= width_in;
   end

endmodule

`default_nettype wire

// ----- src/srsd_queue.sv -----
// Short entry queue between parser front end and result emitter.
// Depends on srsd_pkg.
`default_nettype none

module srsd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire srsd_pkg::entry_type  push_data,
   input  wire logic                 pop,
   output srsd_pkg::entry_type       head,
   output logic                      empty,
   output logic                      full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   srsd_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/srsd_back.sv -----
// Result emitter: expands queue entries into result transfers, adding the
// Annex B start code where flagged, behind an output register. Depends on srsd_pkg.
`default_nettype none

module srsd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire srsd_pkg::entry_type  head,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output srsd_pkg::result_type      rsp
);

   logic                  valid_ff, valid_in;
   srsd_pkg::result_type  out_ff, out_in;
   logic [1:0]            sub_ff, sub_in;
   logic                  load;
   logic                  in_prefix;

   assign rsp_empty = !valid_ff;
   assign rsp       = out_ff;
   assign load      = !q_empty && (!valid_ff || rsp_pop);
   assign in_prefix = head.start_code && (sub_ff != 2'd3);
   assign q_pop     = load && !in_prefix;

   // Select the next result: start code bytes first, then the entry itself
   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         valid_in = 1'b1;
         if (in_prefix) begin
            out_in                 = '0;
            out_in.record_type     = head.res.record_type;
            out_in.field_index     = head.res.field_index;
            out_in.value           = (sub_ff == 2'd2) ? 64'd1 : 64'd0;
            out_in.is_payload_byte = 1'b1;
            sub_in                 = sub_ff + 2'd1;
         end else begin
            out_in = head.res;
            sub_in = 2'd0;
         end
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   // Output payload holds until the next load
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ----- src/sensor_record_stream_deframer_core.sv -----
// Top level of the sensor record stream deframer: parser front end, entry
// queue and result emitter. Depends on srsd_pkg, srsd_front, srsd_queue, srsd_back.
//
//   Channel   Handshake            Payload
//   req_      req_push / req_full  req_data_byte[7:0]
//   rsp_      rsp_pop / rsp_empty  rsp_record_type, rsp_field_index, rsp_value,
//                                  rsp_is_payload_byte, rsp_unit_end,
//                                  rsp_record_end, rsp_unknown_type
//   csr_      csr_write_enable     csr_type_enable[6:0]
//
// One byte is taken per cycle while req_full is low; an entry moves from the queue
// into the output register when that register is empty or being popped. The output
// gives one result per cycle while rsp_pop is held and entries wait, and the first
// byte of a NAL unit yields four results (start code bytes plus the byte); the
// QUEUE_DEPTH-entry queue absorbs these bursts and req_full rises only when it
// fills. Reset is synchronous; there is no clearing pass.
`default_nettype none

module sensor_record_stream_deframer_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_record_type,
   output logic [2:0]       rsp_field_index,
   output logic [63:0]      rsp_value,
   output logic             rsp_is_payload_byte,
   output logic             rsp_unit_end,
   output logic             rsp_record_end,
   output logic             rsp_unknown_type,
   input  wire logic        csr_write_enable,
   input  wire logic [6:0]  csr_type_enable
);

   logic                  req_accept;
   logic                  ent_push;
   srsd_pkg::entry_type   ent;
   srsd_pkg::entry_type   head;
   logic                  q_empty;
   logic                  q_full;
   logic                  q_pop;
   srsd_pkg::result_type  rsp;

   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;

   srsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_type_enable  (csr_type_enable),
      .accept           (req_accept),
      .data_byte        (req_data_byte),
      .ent_push         (ent_push),
      .ent              (ent)
   );

   srsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ent_push),
      .push_data (ent),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   srsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_record_type     = rsp.record_type;
   assign rsp_field_index     = rsp.field_index;
   assign rsp_value           = rsp.value;
   assign rsp_is_payload_byte = rsp.is_payload_byte;
   assign rsp_unit_end        = rsp.unit_end;
   assign rsp_record_end      = rsp.record_end;
   assign rsp_unknown_type    = rsp.unknown_type;

endmodule

`default_nettype wire

// ----- src/srsd_checker.sv -----
// Port-level checker for the sensor record stream deframer, bound to the top.
// Depends on sensor_record_stream_deframer_core.
`default_nettype none

module srsd_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_full,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [2:0]  rsp_field_index,
   input  wire logic [63:0] rsp_value,
   input  wire logic        rsp_is_payload_byte,
   input  wire logic        rsp_unit_end,
   input  wire logic        rsp_record_end,
   input  wire logic        rsp_unknown_type
);

   // Reset empties both sides
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

   // A waiting result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_value)
                                    && $stable(rsp_field_index)))
      else $error("stalled result changed");

   // Unknown-type report is an end marker closing the record
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unknown_type) |->
         (rsp_record_end && rsp_field_index == 3'd7 && rsp_value == 64'd0))
      else $error("malformed unknown-type report");

   // Unit end only on payload bytes
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unit_end) |-> (rsp_is_payload_byte && !rsp_unknown_type))
      else $error("unit end on non-payload result");

   // Payload bytes carry a single byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_payload_byte) |-> (rsp_value[63:8] == 56'd0))
      else $error("payload byte wider than eight bits");

endmodule

bind sensor_record_stream_deframer_core srsd_checker u_srsd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_field_index     (rsp_field_index),
   .rsp_value           (rsp_value),
   .rsp_is_payload_byte (rsp_is_payload_byte),
   .rsp_unit_end        (rsp_unit_end),
   .rsp_record_end      (rsp_record_end),
   .rsp_unknown_type    (rsp_unknown_type)
);

`default_nettype wire
